FILE: rtl/core/rsts_pkg.sv
// Shared types, codes and constants for the record slot table.
`timescale 1ns / 1ps

package rsts_pkg;

    localparam int SLOTS_DEFAULT = 64;
    localparam int IDENT_W       = 16;
    localparam int KEY_W         = 37;
    localparam int SLOT_W        = 6;

    localparam logic [KEY_W-1:0] KEY_MAX = 37'd99999999999;

    // Function codes
    localparam logic [2:0] FUNC_INSERT   = 3'd0;
    localparam logic [2:0] FUNC_MODIFY   = 3'd1;
    localparam logic [2:0] FUNC_DELETE   = 3'd2;
    localparam logic [2:0] FUNC_FIND     = 3'd3;
    localparam logic [2:0] FUNC_SORT_ID  = 3'd4;
    localparam logic [2:0] FUNC_SORT_KEY = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    // Result slot source
    localparam logic [1:0] SLOT_ZERO = 2'd0;
    localparam logic [1:0] SLOT_IDX  = 2'd1;
    localparam logic [1:0] SLOT_PEND = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic [IDENT_W-1:0] ident;
        logic [KEY_W-1:0]   key_value;
        logic               ascending;
    } request_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [SLOT_W-1:0]  slot;
        logic [IDENT_W-1:0] assigned_ident;
    } result_t;

    typedef struct packed {
        logic [IDENT_W-1:0] ident;
        logic [KEY_W-1:0]   key;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic       load;
        logic       idx_clr;
        logic       idx_inc;
        logic       srch;
        logic       ins_write;
        logic       mod_write;
        logic       del_clear;
        logic       carry_load;
        logic       sort_step;
        logic       sort_last;
        logic       swap_clr;
        logic       fin;
        logic [1:0] fin_status;
        logic [1:0] fin_slot;
        logic       fin_new_ident;
    } ctl_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       free_here;
        logic       scan_end;
        logic       hit;
        logic       miss;
        logic       last_pair;
        logic       swapped;
    } dp_status_t;

endpackage

FILE: rtl/core/rsts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rsts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/rsts_datapath.sv
// Slot table datapath: used bits, entry RAM, scan index, sort carry and result registers.
`timescale 1ns / 1ps

module rsts_datapath #(
    parameter int SLOTS = rsts_pkg::SLOTS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rsts_pkg::request_t  request,
    input  rsts_pkg::ctl_cmd_t  cmd,
    output rsts_pkg::dp_status_t sts,
    output logic                done,
    output rsts_pkg::result_t   result
);

    import rsts_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    // Control state
    logic [CW-1:0]      idx_reg, idx_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [AW-1:0]      pend_idx_reg, pend_idx_next;
    logic               swapped_reg, swapped_next;
    logic [IDENT_W-1:0] next_ident_reg, next_ident_next;
    logic [SLOTS-1:0]   used_reg, used_next;
    logic               done_reg, done_next;

    // Payload
    logic [2:0]         func_reg, func_next;
    logic [IDENT_W-1:0] ident_reg, ident_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               asc_reg, asc_next;
    entry_t             carry_reg, carry_next;
    result_t            result_reg, result_next;

    logic [AW-1:0]      addr;
    logic [CW-1:0]      idx_dec;
    logic [AW-1:0]      prev_addr;
    logic               in_range;
    entry_t             rd_entry;
    logic [ENTRY_W-1:0] rd_raw;
    logic               we;
    logic [AW-1:0]      waddr;
    entry_t             wdata;
    logic               by_key;
    logic [KEY_W-1:0]   x_val, y_val;
    logic               swap;
    logic               hit;
    logic [KEY_W-1:0]   key_sat;

    assign addr      = idx_reg[AW-1:0];
    assign idx_dec   = idx_reg - CW'(1);
    assign prev_addr = idx_dec[AW-1:0];
    assign in_range  = idx_reg < CW'(SLOTS);
    assign rd_entry  = entry_t'(rd_raw);
    assign key_sat   = (request.key_value > KEY_MAX) ? KEY_MAX : request.key_value;

    rsts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (addr),
        .rdata (rd_raw)
    );

    // Sort compare: carried entry sits at slot idx-1, read data is slot idx
    assign by_key = (func_reg == FUNC_SORT_KEY);
    assign x_val  = by_key ? carry_reg.key : KEY_W'(carry_reg.ident);
    assign y_val  = by_key ? rd_entry.key  : KEY_W'(rd_entry.ident);
    assign swap   = used_reg[prev_addr] && used_reg[addr]
                    && (asc_reg ? (x_val > y_val) : (x_val < y_val));

    assign hit = pend_valid_reg && used_reg[pend_idx_reg] && (rd_entry.ident == ident_reg);

    assign sts.func      = func_reg;
    assign sts.free_here = in_range && !used_reg[addr];
    assign sts.scan_end  = !in_range;
    assign sts.hit       = hit;
    assign sts.miss      = pend_valid_reg && !hit && (pend_idx_reg == AW'(SLOTS - 1));
    assign sts.last_pair = (idx_reg == CW'(SLOTS - 1));
    assign sts.swapped   = swapped_reg;

    // RAM write port
    always_comb
    begin
        we    = 1'b0;
        waddr = addr;
        wdata = carry_reg;
        priority if (cmd.ins_write)
        begin
            we    = 1'b1;
            waddr = addr;
            wdata = '{ident: next_ident_reg, key: key_reg};
        end
        else if (cmd.mod_write)
        begin
            we    = 1'b1;
            waddr = pend_idx_reg;
            wdata = '{ident: rd_entry.ident, key: key_reg};
        end
        else if (cmd.sort_step)
        begin
            we    = 1'b1;
            waddr = prev_addr;
            wdata = swap ? rd_entry : carry_reg;
        end
        else if (cmd.sort_last)
        begin
            we    = 1'b1;
            waddr = AW'(SLOTS - 1);
            wdata = carry_reg;
        end
    end

    always_comb
    begin
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        swapped_next    = swapped_reg;
        next_ident_next = next_ident_reg;
        used_next       = used_reg;
        done_next       = cmd.fin;
        func_next       = func_reg;
        ident_next      = ident_reg;
        key_next        = key_reg;
        asc_next        = asc_reg;
        carry_next      = carry_reg;
        result_next     = result_reg;

        if (cmd.load)
        begin
            func_next       = request.func;
            ident_next      = request.ident;
            key_next        = key_sat;
            asc_next        = request.ascending;
            idx_next        = '0;
            pend_valid_next = 1'b0;
            swapped_next    = 1'b0;
        end
        else
        begin
            if (cmd.idx_clr)
            begin
                idx_next = '0;
            end
            else if (cmd.idx_inc || (cmd.srch && in_range))
            begin
                idx_next = idx_reg + CW'(1);
            end
            if (cmd.srch)
            begin
                pend_valid_next = in_range;
                pend_idx_next   = addr;
            end
            if (cmd.swap_clr)
            begin
                swapped_next = 1'b0;
            end
            else if (cmd.sort_step && swap)
            begin
                swapped_next = 1'b1;
            end
        end

        if (cmd.ins_write)
        begin
            used_next[addr] = 1'b1;
            next_ident_next = next_ident_reg + IDENT_W'(1);
        end
        if (cmd.del_clear)
        begin
            used_next[pend_idx_reg] = 1'b0;
        end

        if (cmd.carry_load)
        begin
            carry_next = rd_entry;
        end
        else if (cmd.sort_step)
        begin
            carry_next = swap ? carry_reg : rd_entry;
        end

        if (cmd.fin)
        begin
            result_next.status         = cmd.fin_status;
            result_next.assigned_ident = cmd.fin_new_ident ? next_ident_reg : ident_reg;
            unique case (cmd.fin_slot)
                SLOT_IDX:  result_next.slot = SLOT_W'(addr);
                SLOT_PEND: result_next.slot = SLOT_W'(pend_idx_reg);
                default:   result_next.slot = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
            swapped_reg    <= 1'b0;
            next_ident_reg <= '0;
            used_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            pend_idx_reg   <= pend_idx_next;
            swapped_reg    <= swapped_next;
            next_ident_reg <= next_ident_next;
            used_reg       <= used_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        ident_reg  <= ident_next;
        key_reg    <= key_next;
        asc_reg    <= asc_next;
        carry_reg  <= carry_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: rtl/core/rsts_ctrl.sv
// Slot table controller: sequences insert scan, identifier search and bubble sort passes.
`timescale 1ns / 1ps

module rsts_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [2:0]           func,
    input  rsts_pkg::dp_status_t sts,
    output logic                 busy,
    output rsts_pkg::ctl_cmd_t   cmd
);

    import rsts_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS     = 4'd1;
    localparam logic [3:0] S_SRCH    = 4'd2;
    localparam logic [3:0] S_SLOAD_W = 4'd3;
    localparam logic [3:0] S_SLOAD   = 4'd4;
    localparam logic [3:0] S_SWAIT   = 4'd5;
    localparam logic [3:0] S_SCMP    = 4'd6;
    localparam logic [3:0] S_SEND    = 4'd7;
    localparam logic [3:0] S_NOP     = 4'd8;

    logic [3:0] state_reg, state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    unique case (func)
                        FUNC_INSERT:                        state_next = S_INS;
                        FUNC_MODIFY, FUNC_DELETE, FUNC_FIND: state_next = S_SRCH;
                        FUNC_SORT_ID, FUNC_SORT_KEY:         state_next = S_SLOAD_W;
                        default:                             state_next = S_NOP;
                    endcase
                end
            end
            S_INS:
            begin
                priority if (sts.scan_end)
                begin
                    cmd.fin        = 1'b1;
                    cmd.fin_status = ST_FULL;
                    cmd.fin_slot   = SLOT_ZERO;
                    state_next     = S_IDLE;
                end
                else if (sts.free_here)
                begin
                    cmd.ins_write     = 1'b1;
                    cmd.fin           = 1'b1;
                    cmd.fin_status    = ST_OK;
                    cmd.fin_slot      = SLOT_IDX;
                    cmd.fin_new_ident = 1'b1;
                    state_next        = S_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_SRCH:
            begin
                // reads are issued one slot ahead of the compare
                cmd.srch = 1'b1;
                priority if (sts.hit)
                begin
                    cmd.mod_write  = (sts.func == FUNC_MODIFY);
                    cmd.del_clear  = (sts.func == FUNC_DELETE);
                    cmd.fin        = 1'b1;
                    cmd.fin_status = ST_OK;
                    cmd.fin_slot   = SLOT_PEND;
                    state_next     = S_IDLE;
                end
                else if (sts.miss)
                begin
                    cmd.fin        = 1'b1;
                    cmd.fin_status = ST_MISSING;
                    cmd.fin_slot   = SLOT_ZERO;
                    state_next     = S_IDLE;
                end
            end
            S_SLOAD_W:
            begin
                state_next = S_SLOAD;
            end
            S_SLOAD:
            begin
                cmd.carry_load = 1'b1;
                cmd.idx_inc    = 1'b1;
                state_next     = S_SWAIT;
            end
            S_SWAIT:
            begin
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                cmd.sort_step = 1'b1;
                if (sts.last_pair)
                begin
                    state_next = S_SEND;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SWAIT;
                end
            end
            S_SEND:
            begin
                cmd.sort_last = 1'b1;
                if (sts.swapped)
                begin
                    cmd.idx_clr  = 1'b1;
                    cmd.swap_clr = 1'b1;
                    state_next   = S_SLOAD_W;
                end
                else
                begin
                    cmd.fin        = 1'b1;
                    cmd.fin_status = ST_OK;
                    cmd.fin_slot   = SLOT_ZERO;
                    state_next     = S_IDLE;
                end
            end
            S_NOP:
            begin
                cmd.fin        = 1'b1;
                cmd.fin_status = ST_OK;
                cmd.fin_slot   = SLOT_ZERO;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/record_slot_table_with_sort_core.sv
// Top level of the record slot table with identifier allocation and sorting.
//
//   channel   signals                 direction  transfer when
//   request   start, busy, request    in         start high and busy low at clk rise
//   result    done, result            out        done high (one cycle, no back-pressure)
//
// Insert scans used bits one slot a cycle and stops at the first free slot, or reports full.
// Modify, delete and find scan the entry RAM pipelined one slot a cycle through its single
// read port, stopping at the hit or, on a miss, after the last slot.
// A sort pass makes one RAM read per compare; passes repeat until one makes no swap.
// Reset clears all used bits and the identifier counter at once.
// A new request may be taken in the cycle its predecessor's result is shown.
`timescale 1ns / 1ps

module record_slot_table_with_sort_core #(
    parameter int SLOTS = rsts_pkg::SLOTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  rsts_pkg::request_t request,
    output logic               done,
    output rsts_pkg::result_t  result
);

    import rsts_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t sts;

    rsts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (request.func),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    rsts_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .sts     (sts),
        .done    (done),
        .result  (result)
    );

    // every result closes a busy period
    a_done_after_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)
    ) else $error("result without a preceding busy period");

    a_accept_sets_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy
    ) else $error("accepted request did not raise busy");

    a_error_slot_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_OK)) |-> (result.slot == '0)
    ) else $error("error result carries a nonzero slot");

    a_full_only_insert: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_FULL)) |-> (sts.func == FUNC_INSERT)
    ) else $error("table full reported for a non-insert request");

endmodule
